### rtl/core/aesd_pkg.sv
// ----------------------------------------------------------------------------
// aesd_pkg
// shared types, constants and byte- and state-level functions of the aes block decrypt
// ----------------------------------------------------------------------------
package aesd_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_WORD_0 = 3'd0,
    REG_KEY_WORD_1 = 3'd1,
    REG_KEY_WORD_2 = 3'd2,
    REG_KEY_WORD_3 = 3'd3,
    REG_KEY_SIZE   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KEY_128 = 2'd0,
    KEY_192 = 2'd1,
    KEY_256 = 2'd2
  } key_size_t;

  // controller to datapath
  typedef struct packed {
    logic       exp_start;   // reset the expansion count and rcon, start expansion
    logic       exp_step;    // compute one round-key word, write each full row of four
    logic       blk_load;    // take a ciphertext word, add last round key, inverse shift and sub
    logic       rnd_step;    // one inverse round
    logic       rnd_last;    // final round, add round key only, no inverse mix columns
    logic       out_load;    // move the state to the output register
    logic [5:0] rd_addr;     // round-key row (group of four words) read
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       exp_done;
    logic [3:0] nr;          // number of rounds of the active key size
  } dp_sts_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    gf_mul = p;
  endfunction

  function automatic logic [7:0] gf_inv(input logic [7:0] x);
    logic [7:0] p;
    logic [7:0] sq;
    p  = 8'h01;
    sq = x;
    // x^254 = x^2 * x^4 * ... * x^128
    for (int i = 0; i < 7; i++) begin
      sq = gf_mul(sq, sq);
      p  = gf_mul(p, sq);
    end
    gf_inv = p;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] b, input int unsigned n);
    rotl8 = 8'((b << n) | (b >> (8 - n)));
  endfunction

  function automatic logic [7:0] sbox_calc(input logic [7:0] x);
    logic [7:0] b;
    b = gf_inv(x);
    sbox_calc = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] inv_sbox_calc(input logic [7:0] s);
    inv_sbox_calc = gf_inv(rotl8(s, 1) ^ rotl8(s, 3) ^ rotl8(s, 6) ^ 8'h05);
  endfunction

  typedef logic [7:0] sbox_tbl_t [256];

  function automatic sbox_tbl_t make_sbox(input logic inv);
    sbox_tbl_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = inv ? inv_sbox_calc(8'(i)) : sbox_calc(8'(i));
    end
    make_sbox = t;
  endfunction

  localparam sbox_tbl_t SBOX     = make_sbox(1'b0);
  localparam sbox_tbl_t INV_SBOX = make_sbox(1'b1);

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // state as 128 bits, byte 0 in [127:120], column-major
  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] o;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127-8*(r+4*c) -: 8] = INV_SBOX[s[127-8*(r+4*((c+4-r)%4)) -: 8]];
      end
    end
    inv_shift_sub = o;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] o;
    logic [7:0]   a0, a1, a2, a3;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      o[127-32*c -: 8] = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^ gf_mul(a2, 8'd13)
                         ^ gf_mul(a3, 8'd9);
      o[119-32*c -: 8] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14) ^ gf_mul(a2, 8'd11)
                         ^ gf_mul(a3, 8'd13);
      o[111-32*c -: 8] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9) ^ gf_mul(a2, 8'd14)
                         ^ gf_mul(a3, 8'd11);
      o[103-32*c -: 8] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^ gf_mul(a2, 8'd9)
                         ^ gf_mul(a3, 8'd14);
    end
    inv_mix = o;
  endfunction

endpackage

### rtl/core/aesd_ram.sv
// ----------------------------------------------------------------------------
// aesd_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module aesd_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/aesd_ctrl.sv
// ----------------------------------------------------------------------------
// aesd_ctrl
// sequencer: key expansion trigger, round counting and the handshakes
// ----------------------------------------------------------------------------
module aesd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  logic             cfg_write,
  input  aesd_pkg::dp_sts_t sts,
  output aesd_pkg::dp_cmd_t cmd
);
  import aesd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXP, ST_RD, ST_LOAD, ST_ROUND
  } state_t;

  state_t     state_r, state_nxt;
  logic       ready_r, ready_nxt;     // keys expanded
  logic       ovalid_r, ovalid_nxt;
  logic [3:0] rnd_r, rnd_nxt;         // round key row being used next
  logic       in_acc;

  assign in_tready  = (state_r == ST_IDLE) && !cfg_write;
  assign out_tvalid = ovalid_r;
  assign in_acc     = in_tvalid && in_tready;

  always_comb begin
    state_nxt  = state_r;
    ready_nxt  = ready_r;
    ovalid_nxt = ovalid_r && !out_tready;
    rnd_nxt    = rnd_r;
    cmd        = '0;
    cmd.rd_addr = {2'b00, rnd_r};
    if (cfg_write) ready_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.rd_addr = {2'b00, sts.nr};
        if (in_acc) begin
          if (!ready_r) begin
            cmd.exp_start = 1'b1;
            state_nxt = ST_EXP;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_EXP: begin
        cmd.exp_step = 1'b1;
        if (sts.exp_done) begin
          ready_nxt = 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        // ram read of the last round key row
        cmd.rd_addr = {2'b00, sts.nr};
        rnd_nxt   = sts.nr - 4'd1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.blk_load = 1'b1;
        rnd_nxt   = rnd_r - 4'd1;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        // held while the previous result is still unread
        if (!ovalid_r || out_tready) begin
          cmd.rnd_step = 1'b1;
          if (rnd_r == 4'd15) begin
            cmd.rnd_last = 1'b1;
            cmd.out_load = 1'b1;
            ovalid_nxt   = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            rnd_nxt = rnd_r - 4'd1;
          end
        end else begin
          cmd.rd_addr = {2'b00, rnd_r + 4'd1};
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ready_r  <= 1'b0;
      ovalid_r <= 1'b0;
      rnd_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      ready_r  <= ready_nxt;
      ovalid_r <= ovalid_nxt;
      rnd_r    <= rnd_nxt;
    end
  end

endmodule

### rtl/core/aesd_dp.sv
// ----------------------------------------------------------------------------
// aesd_dp
// key registers, key schedule, round-key ram and inverse round datapath
// ----------------------------------------------------------------------------
module aesd_dp #(
  parameter int unsigned ROUND_KEY_WORDS = 60
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_write,
  input  logic [aesd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [63:0]                        cfg_data,
  input  logic [127:0]                       blk_in,
  output logic [127:0]                       blk_out,
  input  aesd_pkg::dp_cmd_t                  cmd,
  output aesd_pkg::dp_sts_t                  sts
);
  import aesd_pkg::*;

  localparam int unsigned ROWS = ROUND_KEY_WORDS / 4;
  localparam int unsigned RA_W = $clog2(ROWS);
  // largest key size whose schedule fits
  localparam logic [1:0] KS_MAX = (ROUND_KEY_WORDS >= 60) ? KEY_256 :
                                  (ROUND_KEY_WORDS >= 52) ? KEY_192 : KEY_128;

  logic [63:0]  kw_r [4];
  logic [1:0]   ksz_r;
  logic [1:0]   ks;
  logic [3:0]   nk;
  logic [3:0]   nr;

  // sliding window of the last eight key words, [0] newest
  logic [31:0]  win_r [8];
  logic [5:0]   i_r;       // index of next word to produce
  logic [3:0]   imod_r;    // i mod nk
  logic [7:0]   rcon_r;
  logic [5:0]   total;
  logic [31:0]  prev, back, t, neww;
  logic [127:0] row_acc_r;
  logic         row_we;
  logic [127:0] row_wdata;

  logic [127:0] rk;
  logic [127:0] st_r, st_nxt, st_ark, st_ss;
  logic [127:0] out_r;

  always_comb begin
    ks = (ksz_r == 2'd3) ? KEY_256 : ksz_r;
    if (ks > KS_MAX) ks = KS_MAX;
    nk = {ks, 1'b0} + 4'd4;
    nr = nk + 4'd6;
    total = 6'({nr, 2'b00} + 6'd4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) kw_r[k] <= '0;
      ksz_r <= KEY_128;
    end else if (cfg_write) begin
      if (cfg_index < CFG_IDX_W'(REG_KEY_SIZE)) kw_r[cfg_index[1:0]] <= cfg_data;
      else if (cfg_index == CFG_IDX_W'(REG_KEY_SIZE)) ksz_r <= cfg_data[1:0];
    end
  end

  // key schedule, one word per cycle
  always_comb begin
    prev = win_r[0];
    back = win_r[3'(nk - 4'd1)];
    t    = prev;
    if (imod_r == 4'd0) t = sub_word({prev[23:0], prev[31:24]}) ^ {rcon_r, 24'h0};
    else if (nk > 4'd6 && imod_r == 4'd4) t = sub_word(prev);
    if (i_r < {2'b00, nk}) begin
      neww = i_r[0] ? kw_r[i_r[2:1]][31:0] : kw_r[i_r[2:1]][63:32];
    end else begin
      neww = back ^ t;
    end
    row_wdata = {row_acc_r[95:0], neww};
    row_we    = cmd.exp_step && (i_r[1:0] == 2'b11);
  end

  always_ff @(posedge clk) begin
    if (cmd.exp_start) begin
      i_r    <= '0;
      imod_r <= '0;
      rcon_r <= 8'h01;
    end else if (cmd.exp_step) begin
      i_r    <= i_r + 6'd1;
      imod_r <= (imod_r == nk - 4'd1) ? 4'd0 : imod_r + 4'd1;
      if (i_r >= {2'b00, nk} && imod_r == 4'd0) rcon_r <= xtime(rcon_r);
      win_r[0] <= neww;
      for (int k = 1; k < 8; k++) win_r[k] <= win_r[k-1];
      row_acc_r <= row_wdata;
    end
  end

  assign sts.exp_done = cmd.exp_step && (i_r == total - 6'd1);
  assign sts.nr       = nr;

  aesd_ram #(.WIDTH(128), .DEPTH(ROWS)) u_rk_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (RA_W'(i_r[5:2])),
    .wdata (row_wdata),
    .raddr (RA_W'(cmd.rd_addr)),
    .rdata (rk)
  );

  // one inverse round: add key, then inverse mix, shift and sub unless last; load: add key, shift, sub
  always_comb begin
    st_ark = st_r ^ rk;
    st_ss  = inv_shift_sub(cmd.rnd_last ? st_ark : inv_mix(st_ark));
    st_nxt = st_r;
    if (cmd.blk_load) st_nxt = inv_shift_sub(blk_in ^ rk);
    else if (cmd.rnd_step) st_nxt = cmd.rnd_last ? st_ark : st_ss;
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    if (cmd.out_load) out_r <= st_ark;
  end

  assign blk_out = out_r;

endmodule

### rtl/core/aes_block_decrypt.sv
// ----------------------------------------------------------------------------
// aes_block_decrypt
// aes inverse cipher for 128, 192 and 256 bit keys with an on-chip key schedule
// ----------------------------------------------------------------------------
// channel | direction | handshake           | content
// in_     | input     | in_tvalid/in_tready | ciphertext word
// out_    | output    | out_tvalid/out_tready | plaintext word
// cfg_    | input     | cfg_valid/cfg_ready | key registers and key size
//
// a word passes through the single shared round unit, one round per cycle
// with round keys from the round-key ram
// the first word after reset or a register write adds 4*(nr+1) key words
// of key expansion, one key word per cycle
// reset is synchronous, active low; no clearing pass is needed
// every round waits while a previous result is still untaken
module aes_block_decrypt #(
  parameter int unsigned ROUND_KEY_WORDS = 60
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [127:0]                   in_tdata,   // block_low, block_high
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [127:0]                   out_tdata,  // plain_low, plain_high
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [aesd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data
);
  import aesd_pkg::*;

  dp_cmd_t      cmd;
  dp_sts_t      sts;
  logic         cfg_write;
  logic [127:0] blk_out;

  // register writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid;

  aesd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_write  (cfg_write),
    .sts        (sts),
    .cmd        (cmd)
  );

  // ciphertext is captured at accept into the datapath through a hold register
  logic [127:0] blk_r;
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) blk_r <= {in_tdata[63:0], in_tdata[127:64]};
  end

  aesd_dp #(.ROUND_KEY_WORDS(ROUND_KEY_WORDS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .blk_in    (blk_r),
    .blk_out   (blk_out),
    .cmd       (cmd),
    .sts       (sts)
  );

  // state is held high-byte-first; word carries plain_high in the low bits
  assign out_tdata = {blk_out[63:0], blk_out[127:64]};

endmodule

### tb/tb_aes_block_decrypt.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_aes_block_decrypt
// self-checking bench: ciphertext words go in under random idling, each
// plaintext word is checked against a behavioral inverse cipher kept here
// ----------------------------------------------------------------------------
module tb_aes_block_decrypt;
  import aesd_pkg::*;

  localparam int unsigned RK_WORDS  = 60;
  localparam int unsigned MAX_CYC   = 2000000;
  localparam int unsigned N_RANDOM  = 1250;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;   // block_low, block_high
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;  // plain_low, plain_high
  logic         cfg_valid;
  logic         cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0]  cfg_data;

  aes_block_decrypt #(.ROUND_KEY_WORDS(RK_WORDS)) uut (.*);

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // key state of the predictor
  logic [63:0]  key_word [4];
  logic [1:0]   key_sz;
  logic [31:0]  sched [RK_WORDS];
  logic         sched_valid;
  int unsigned  n_rounds;

  logic [127:0] word_q [$];      // ciphertext words waiting for the driver
  logic [127:0] plain_q [$];     // expected plaintext words
  int unsigned  errors;
  int unsigned  cycles;
  logic         hold_out;        // long receiver stall request
  logic         hold_in;         // sender pause request
  logic         in_fire;         // input word taken at the last rising edge
  logic         out_fire;        // result word taken at the last rising edge

  // byte helpers written from first principles
  function automatic logic [7:0] mul2(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = mul2(a);
    end
    return p;
  endfunction

  function automatic logic [7:0] ginv(input logic [7:0] x);
    logic [7:0] r;
    r = 8'h01;
    for (int i = 0; i < 254; i++) r = gmul(r, x);
    return r;
  endfunction

  logic [7:0] fwd_tab [256];
  logic [7:0] inv_tab [256];

  function automatic logic [7:0] rl(input logic [7:0] b, input int n);
    return (b << n) | (b >> (8 - n));
  endfunction

  task automatic build_tables();
    logic [7:0] b;
    for (int i = 0; i < 256; i++) begin
      b = ginv(8'(i));
      fwd_tab[i] = b ^ rl(b, 1) ^ rl(b, 2) ^ rl(b, 3) ^ rl(b, 4) ^ 8'h63;
    end
    for (int i = 0; i < 256; i++) inv_tab[fwd_tab[i]] = 8'(i);
  endtask

  function automatic logic [31:0] subw(input logic [31:0] w);
    return {fwd_tab[w[31:24]], fwd_tab[w[23:16]], fwd_tab[w[15:8]], fwd_tab[w[7:0]]};
  endfunction

  task automatic expand_schedule();
    int unsigned ks, nk, total;
    logic [7:0]  rcon;
    logic [31:0] t;
    ks = (key_sz > 2) ? 2 : key_sz;
    // shrink the key size if the store cannot hold it
    while (ks > 0 && 4 * (2 * ks + 11) > RK_WORDS) ks--;
    nk = 2 * ks + 4;
    n_rounds = nk + 6;
    total = 4 * (n_rounds + 1);
    rcon = 8'h01;
    for (int i = 0; i < total; i++) begin
      if (i < nk) begin
        sched[i] = (i % 2) ? key_word[i / 2][31:0] : key_word[i / 2][63:32];
      end else begin
        t = sched[i - 1];
        if (i % nk == 0) begin
          t = subw({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
          rcon = mul2(rcon);
        end else if (nk > 6 && i % nk == 4) begin
          t = subw(t);
        end
        sched[i] = sched[i - nk] ^ t;
      end
    end
    sched_valid = 1'b1;
  endtask

  // state bytes: st[k] is byte k, column-major
  function automatic logic [127:0] decrypt_word(input logic [127:0] ct);
    logic [7:0] st [16];
    logic [7:0] tmp [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] res;
    for (int k = 0; k < 16; k++) st[k] = (k < 8) ? ct[63 - 8*k -: 8] : ct[127 - 8*(k-8) -: 8];
    for (int rd = n_rounds; rd >= 0; rd--) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) st[4*c+r] ^= sched[4*rd+c][31 - 8*r -: 8];
      if (rd == 0) break;
      if (rd != n_rounds) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
          st[4*c]   = gmul(a0, 14) ^ gmul(a1, 11) ^ gmul(a2, 13) ^ gmul(a3, 9);
          st[4*c+1] = gmul(a0, 9) ^ gmul(a1, 14) ^ gmul(a2, 11) ^ gmul(a3, 13);
          st[4*c+2] = gmul(a0, 13) ^ gmul(a1, 9) ^ gmul(a2, 14) ^ gmul(a3, 11);
          st[4*c+3] = gmul(a0, 11) ^ gmul(a1, 13) ^ gmul(a2, 9) ^ gmul(a3, 14);
        end
      end
      tmp = st;
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) st[r+4*c] = inv_tab[tmp[r + 4*((c+4-r)%4)]];
    end
    for (int k = 0; k < 16; k++) begin
      if (k < 8) res[63 - 8*k -: 8] = st[k];
      else res[127 - 8*(k-8) -: 8] = st[k];
    end
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // predicts at queue time; the driver keeps order so this matches acceptance
  task automatic queue_word(input logic [127:0] w);
    if (!sched_valid) expand_schedule();
    word_q.push_back(w);
    plain_q.push_back(decrypt_word(w));
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_KEY_SIZE) key_sz = val[1:0];
    else key_word[2'(idx)] = val;
    sched_valid = 1'b0;
  endtask

  task automatic drain();
    while (word_q.size() != 0 || plain_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic load_key(input logic [1:0] sz, input logic [63:0] k0, input logic [63:0] k1,
                          input logic [63:0] k2, input logic [63:0] k3);
    write_reg(REG_KEY_WORD_0, k0);
    write_reg(REG_KEY_WORD_1, k1);
    write_reg(REG_KEY_WORD_2, k2);
    write_reg(REG_KEY_WORD_3, k3);
    write_reg(REG_KEY_SIZE, {62'd0, sz});
  endtask

  // handshakes seen at the rising edge, used by the falling-edge processes
  always @(posedge clk) begin
    in_fire  <= rst_n && in_tvalid && in_tready;
    out_fire <= rst_n && out_tvalid && out_tready;
  end

  // driver: one word at a time with a random gap before each
  int unsigned in_gap;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
    end else if (in_tvalid && !in_fire) begin
      // hold the offered word
    end else if (in_tvalid && in_fire) begin
      // word accepted at the last rising edge
      void'(word_q.pop_front());
      if (word_q.size() != 0 && !hold_in && $urandom_range(0, 14) == 0 && in_gap == 0) begin
        in_tdata <= word_q[0];
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
        in_gap <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 14);
      end
    end else if (in_gap != 0) begin
      in_gap <= in_gap - 1;
    end else if (word_q.size() != 0 && !hold_in) begin
      in_tdata  <= word_q[0];
      in_tvalid <= 1'b1;
    end
  end

  // receiver: random stall per word plus a forced long stall
  int unsigned out_gap;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap    <= 0;
    end else if (hold_out) begin
      out_tready <= 1'b0;
    end else if (out_fire) begin
      out_gap <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 14);
      out_tready <= 1'b0;
    end else if (out_gap != 0) begin
      out_gap <= out_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor: compare each plaintext word with the oldest expectation
  logic [127:0] exp_w;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (plain_q.size() == 0) begin
        $display("%0t unexpected word: expected none, actual %h", $time, out_tdata);
        errors++;
      end else begin
        exp_w = plain_q.pop_front();
        if (out_tdata[63:0] !== exp_w[63:0]) begin
          $display("%0t plain_high mismatch: expected %h, actual %h", $time,
                   exp_w[63:0], out_tdata[63:0]);
          errors++;
        end
        if (out_tdata[127:64] !== exp_w[127:64]) begin
          $display("%0t plain_low mismatch: expected %h, actual %h", $time,
                   exp_w[127:64], out_tdata[127:64]);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  int unsigned n_left;
  initial begin
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; out_tready = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    hold_out = 1'b0; hold_in = 1'b0;
    errors = 0; cycles = 0;
    key_word = '{default: 64'd0}; key_sz = 2'd0; sched_valid = 1'b0;
    build_tables();
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // directed: reset key, field extremes, half-ones and alternating-bit words
    queue_word('0);
    queue_word('1);
    queue_word({64'h0, 64'hffff_ffff_ffff_ffff});
    queue_word({64'hffff_ffff_ffff_ffff, 64'h0});
    queue_word({64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa});
    queue_word({64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555});
    drain();
    // fips-197 example keys for each size
    load_key(KEY_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 0, 0);
    queue_word({64'h5ac4b4c4_b47a2d81, 64'h69c4e0d8_6a7b0430}); // low, high
    queue_word('1);
    drain();
    load_key(KEY_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617, 0);
    queue_word({64'h2a0dfc9a_4d1d9ba4, 64'hdda97ca4_864cdfe0});
    queue_word('0);
    drain();
    load_key(KEY_256, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
             64'h18191a1b1c1d1e1f);
    queue_word({64'h4960895e_ea4b4c4b, 64'h8ea2b7ca_516745bf});
    drain();
    // key size three behaves as 256
    write_reg(REG_KEY_SIZE, 64'd3);
    queue_word({64'h0123456789abcdef, 64'hfedcba9876543210});
    drain();
    // all-ones keys, all-zero keys
    load_key(KEY_256, '1, '1, '1, '1);
    queue_word('1);
    drain();
    load_key(KEY_128, '0, '0, '0, '0);
    write_reg(REG_KEY_SIZE, '1);
    queue_word('0);
    drain();

    // random phases, each with a fresh key and size
    n_left = N_RANDOM;
    for (int ph = 0; n_left > 0; ph++) begin
      load_key($urandom_range(0, 3), rand64(), rand64(), rand64(), rand64());
      // sometimes rewrite one register alone
      if ($urandom_range(0, 2) == 0) write_reg(cfg_reg_t'($urandom_range(0, 3)), rand64());
      for (int k = 0; k < 100 && n_left > 0; k++, n_left--) queue_word({rand64(), rand64()});
      if (ph == 1) begin
        // long receiver stall while words keep coming
        @(negedge clk) hold_out = 1'b1;
        repeat (400) @(posedge clk);
        @(negedge clk) hold_out = 1'b0;
      end
      if (ph == 3) begin
        // sender pauses until all outstanding results have come
        @(negedge clk) hold_in = 1'b1;
        while (plain_q.size() != word_q.size()) @(posedge clk);
        @(negedge clk) hold_in = 1'b0;
      end
      drain();
    end

    drain();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
